>>> design/sct_pkg.sv
`default_nettype none

package sct_pkg;

  // Default line length; the position counter saturates at MAX_LINE-1
  localparam int unsigned MaxLineDefault = 4096;

  // Result field widths
  localparam int unsigned KindW   = 3;
  localparam int unsigned StartW  = 12;
  localparam int unsigned LengthW = 13;
  localparam int unsigned StatusW = 2;

  // Token kinds
  localparam logic [KindW-1:0] KIND_WORD  = 3'd0;
  localparam logic [KindW-1:0] KIND_GTR   = 3'd1;
  localparam logic [KindW-1:0] KIND_DGTR  = 3'd2;
  localparam logic [KindW-1:0] KIND_BREAK = 3'd3;
  localparam logic [KindW-1:0] KIND_END   = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] STAT_OK = 2'd0;
  localparam logic [StatusW-1:0] STAT_SQ = 2'd1;
  localparam logic [StatusW-1:0] STAT_DQ = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  // Result queue depth (two pushes per request at most)
  localparam int unsigned ResDepth = 4;

  // One result item
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [StartW-1:0]  start;
    logic [LengthW-1:0] length;
    logic [StatusW-1:0] status;
    logic               last;
  } res_t;

  // Results produced by one request
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

`default_nettype wire

>>> design/sct_res_fifo.sv
`default_nettype none

module sct_res_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  sct_pkg::push_t   push_i,
  output logic             space_o,
  output logic             valid_o,
  output sct_pkg::res_t    data_o,
  input  wire              ready_i
);

  localparam int unsigned Depth = sct_pkg::ResDepth;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sct_pkg::res_t       mem_q [Depth];
  logic [IdxW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  // room for the worst case of two results
  assign space_o = cnt_q <= CntW'(Depth - 2);

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q + IdxW'(push_i.count);
    rd_d  = rd_q + IdxW'(pop);
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + IdxW'(1)] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

>>> design/shell_command_tokenizer.sv
// Shell command line tokenizer.
// Input channel: one character per request on ch_i (in_valid_i / in_ready_o);
// a zero byte ends the line. Output channel: tokens as kind, start offset,
// length and status (out_valid_o / out_ready_i); last_o marks the final
// token caused by one character.
// Each character is lexed in the cycle it is accepted: a small mode
// transition plus the position counter update. Its zero, one or two tokens
// enter a four-entry result queue and are visible in the cycle after.
// Throughput: one character per cycle while the queue holds two entries or
// fewer; a character that yields two tokens is output one token at a time,
// so a sustained rate above one token per cycle cannot be kept.
// in_ready_o drops when the queue has fewer than two free entries, which is
// what happens when the receiver stalls; no token is lost.
// Reset: between tokens at line start, position zero, queue empty.
// The position saturates at MAX_LINE-1 on long lines.
`default_nettype none

module shell_command_tokenizer #(
  parameter int unsigned MAX_LINE = sct_pkg::MaxLineDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  ch_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [11:0] token_start_o,
  output logic [12:0] token_length_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam int unsigned PosW = $clog2(MAX_LINE);
  localparam int unsigned LenW = PosW + 1;

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_DIGIT, M_GT, M_DGT, M_WORD, M_ESC, M_DQ, M_DQESC, M_SQ
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [PosW-1:0]   pos_q, pos_d, start_q, start_d;
  logic              accept;
  logic              space;
  logic              do_idle, emit_a, emit_b;
  sct_pkg::res_t     res_a, res_b;
  sct_pkg::push_t    push;
  sct_pkg::res_t     out_res;
  logic [LenW-1:0]   len_ps, len_ps1;
  logic              ends_word;
  mode_e             word_mode;

  assign in_ready_o = space;
  assign accept     = in_valid_i && in_ready_o;

  // pending token lengths
  assign len_ps  = LenW'(pos_q) - LenW'(start_q);
  assign len_ps1 = LenW'(pos_q) + LenW'(1) - LenW'(start_q);

  // word boundary set and mode for a character inside a word
  always_comb begin
    ends_word = ch_i inside {sct_pkg::CH_SPACE, sct_pkg::CH_NL, sct_pkg::CH_SEMI,
                             sct_pkg::CH_NUL, sct_pkg::CH_HASH};
    case (ch_i)
      sct_pkg::CH_DQUOTE: word_mode = M_DQ;
      sct_pkg::CH_SQUOTE: word_mode = M_SQ;
      sct_pkg::CH_BSLASH: word_mode = M_ESC;
      default:            word_mode = M_WORD;
    endcase
  end

  // lexer step
  always_comb begin
    mode_d  = mode_q;
    start_d = start_q;
    do_idle = 1'b0;
    emit_a  = 1'b0;
    emit_b  = 1'b0;
    res_a.kind   = sct_pkg::KIND_WORD;
    res_a.start  = sct_pkg::StartW'(start_q);
    res_a.length = sct_pkg::LengthW'(len_ps);
    res_a.status = sct_pkg::STAT_OK;
    res_a.last   = 1'b1;
    res_b.kind   = sct_pkg::KIND_BREAK;
    res_b.start  = sct_pkg::StartW'(pos_q);
    res_b.length = sct_pkg::LengthW'(1);
    res_b.status = sct_pkg::STAT_OK;
    res_b.last   = 1'b1;

    // token in progress
    case (mode_q)
      M_COMMENT: begin
        if (ch_i == sct_pkg::CH_NL || ch_i == sct_pkg::CH_NUL) do_idle = 1'b1;
      end
      M_DIGIT: begin
        if (ch_i == sct_pkg::CH_GT) begin
          mode_d = M_GT;
        end else if (ends_word) begin
          emit_a  = 1'b1;
          do_idle = 1'b1;
        end else begin
          mode_d = word_mode;
        end
      end
      M_GT, M_DGT: begin
        res_a.kind = (mode_q == M_GT) ? sct_pkg::KIND_GTR : sct_pkg::KIND_DGTR;
        if (mode_q == M_GT && ch_i == sct_pkg::CH_GT) begin
          mode_d = M_DGT;
        end else if (ch_i == sct_pkg::CH_AMP) begin
          emit_a       = 1'b1;
          res_a.length = sct_pkg::LengthW'(len_ps1);
          mode_d       = M_IDLE;
        end else begin
          emit_a  = 1'b1;
          do_idle = 1'b1;
        end
      end
      M_WORD: begin
        if (ends_word) begin
          emit_a  = 1'b1;
          do_idle = 1'b1;
        end else begin
          mode_d = word_mode;
        end
      end
      M_ESC: begin
        if (ch_i == sct_pkg::CH_NUL) begin
          emit_a  = 1'b1;
          do_idle = 1'b1;
        end else begin
          mode_d = M_WORD;
        end
      end
      M_DQ: begin
        res_a.kind   = sct_pkg::KIND_END;
        res_a.status = sct_pkg::STAT_DQ;
        if (ch_i == sct_pkg::CH_NUL) emit_a = 1'b1;
        else if (ch_i == sct_pkg::CH_DQUOTE) mode_d = M_WORD;
        else if (ch_i == sct_pkg::CH_BSLASH) mode_d = M_DQESC;
      end
      M_DQESC: begin
        res_a.kind   = sct_pkg::KIND_END;
        res_a.status = sct_pkg::STAT_DQ;
        if (ch_i == sct_pkg::CH_NUL) emit_a = 1'b1;
        else mode_d = M_DQ;
      end
      M_SQ: begin
        res_a.kind   = sct_pkg::KIND_END;
        res_a.status = sct_pkg::STAT_SQ;
        if (ch_i == sct_pkg::CH_NUL) emit_a = 1'b1;
        else if (ch_i == sct_pkg::CH_SQUOTE) mode_d = M_WORD;
      end
      default: do_idle = 1'b1;
    endcase

    // character seen between tokens
    if (do_idle) begin
      mode_d = M_IDLE;
      case (ch_i)
        sct_pkg::CH_SPACE: ;
        sct_pkg::CH_HASH: mode_d = M_COMMENT;
        sct_pkg::CH_NL, sct_pkg::CH_SEMI: emit_b = 1'b1;
        sct_pkg::CH_NUL: begin
          emit_b       = 1'b1;
          res_b.kind   = sct_pkg::KIND_END;
          res_b.length = '0;
        end
        sct_pkg::CH_GT: begin
          start_d = pos_q;
          mode_d  = M_GT;
        end
        default: begin
          start_d = pos_q;
          if (ch_i inside {[sct_pkg::CH_ZERO:sct_pkg::CH_NINE]}) mode_d = M_DIGIT;
          else mode_d = word_mode;
        end
      endcase
    end

    // line end and position update
    if (ch_i == sct_pkg::CH_NUL) begin
      pos_d   = '0;
      start_d = '0;
      mode_d  = M_IDLE;
    end else if (pos_q < PosW'(MAX_LINE - 1)) begin
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // results for the queue
  always_comb begin
    push.count  = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
    push.first  = emit_a ? res_a : res_b;
    push.second = res_b;
    if (emit_a && emit_b) push.first.last = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      start_q <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  sct_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_valid_o),
    .data_o  (out_res),
    .ready_i (out_ready_i)
  );

  assign token_kind_o   = out_res.kind;
  assign token_start_o  = out_res.start;
  assign token_length_o = out_res.length;
  assign status_o       = out_res.status;
  assign last_o         = out_res.last;

endmodule

`default_nettype wire

>>> test/sct_token_checker.sv
`timescale 1ns / 1ps

module sct_token_checker #(
  parameter int unsigned MAX_LINE = sct_pkg::MaxLineDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [7:0]  ch_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [2:0]  token_kind_i,
  input  wire  [11:0] token_start_i,
  input  wire  [12:0] token_length_i,
  input  wire  [1:0]  status_i,
  input  wire         last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef enum logic [3:0] {
    LEX_IDLE,
    LEX_COMMENT,
    LEX_DIGIT,
    LEX_GT,
    LEX_DGT,
    LEX_WORD,
    LEX_ESC,
    LEX_DQ,
    LEX_DQESC,
    LEX_SQ
  } lex_mode_e;

  // Shadow lexer state
  lex_mode_e   mode      = LEX_IDLE;
  logic [11:0] pos       = '0;
  logic [11:0] tok_start = '0;

  // Tokens produced by the current request
  sct_pkg::res_t step_tok [2];
  int            step_n;

  sct_pkg::res_t expected_tokens [$];
  sct_pkg::res_t want;

  int fails   = 0;
  int pending = 0;
  int checked = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign checked_o    = checked;

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("%0t ns: token %0d %s: expected %0d, got %0d",
             $time, checked, what, want_v, got_v);
    fails++;
  endtask

  function automatic logic ends_word(input logic [7:0] c);
    return c == sct_pkg::CH_SPACE || c == sct_pkg::CH_NL || c == sct_pkg::CH_SEMI ||
           c == sct_pkg::CH_NUL || c == sct_pkg::CH_HASH;
  endfunction

  // Characters from the pending token start up to p (plus one for a trailing '&')
  function automatic logic [12:0] span(input logic [11:0] p, input logic extra);
    return {1'b0, p} + {12'd0, extra} - {1'b0, tok_start};
  endfunction

  task automatic emit_tok(input logic [2:0] kind, input logic [11:0] start,
                          input logic [12:0] len, input logic [1:0] stat);
    sct_pkg::res_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = len;
    tok.status = stat;
    tok.last   = 1'b0;
    if (step_n < 2) begin
      step_tok[step_n] = tok;
      step_n++;
    end
  endtask

  task automatic word_char(input logic [7:0] c);
    if (c == sct_pkg::CH_DQUOTE) mode = LEX_DQ;
    else if (c == sct_pkg::CH_SQUOTE) mode = LEX_SQ;
    else if (c == sct_pkg::CH_BSLASH) mode = LEX_ESC;
    else mode = LEX_WORD;
  endtask

  // Character seen between tokens
  task automatic idle_char(input logic [7:0] c, input logic [11:0] p);
    mode = LEX_IDLE;
    if (c == sct_pkg::CH_HASH) begin
      mode = LEX_COMMENT;
    end else if (c == sct_pkg::CH_NL || c == sct_pkg::CH_SEMI) begin
      emit_tok(sct_pkg::KIND_BREAK, p, 13'd1, sct_pkg::STAT_OK);
    end else if (c == sct_pkg::CH_NUL) begin
      emit_tok(sct_pkg::KIND_END, p, 13'd0, sct_pkg::STAT_OK);
    end else if (c == sct_pkg::CH_GT) begin
      tok_start = p;
      mode = LEX_GT;
    end else if (c >= sct_pkg::CH_ZERO && c <= sct_pkg::CH_NINE) begin
      tok_start = p;
      mode = LEX_DIGIT;
    end else if (c != sct_pkg::CH_SPACE) begin
      tok_start = p;
      word_char(c);
    end
  endtask

  // Lex one accepted character and queue the tokens it yields
  task automatic lex_char(input logic [7:0] c);
    logic [11:0] p;
    p = pos;
    step_n = 0;
    case (mode)
      LEX_COMMENT: begin
        if (c == sct_pkg::CH_NL || c == sct_pkg::CH_NUL) idle_char(c, p);
      end
      LEX_DIGIT: begin
        if (c == sct_pkg::CH_GT) begin
          mode = LEX_GT;
        end else if (ends_word(c)) begin
          emit_tok(sct_pkg::KIND_WORD, tok_start, span(p, 1'b0), sct_pkg::STAT_OK);
          idle_char(c, p);
        end else begin
          word_char(c);
        end
      end
      LEX_GT: begin
        if (c == sct_pkg::CH_GT) begin
          mode = LEX_DGT;
        end else if (c == sct_pkg::CH_AMP) begin
          emit_tok(sct_pkg::KIND_GTR, tok_start, span(p, 1'b1), sct_pkg::STAT_OK);
          mode = LEX_IDLE;
        end else begin
          emit_tok(sct_pkg::KIND_GTR, tok_start, span(p, 1'b0), sct_pkg::STAT_OK);
          idle_char(c, p);
        end
      end
      LEX_DGT: begin
        if (c == sct_pkg::CH_AMP) begin
          emit_tok(sct_pkg::KIND_DGTR, tok_start, span(p, 1'b1), sct_pkg::STAT_OK);
          mode = LEX_IDLE;
        end else begin
          emit_tok(sct_pkg::KIND_DGTR, tok_start, span(p, 1'b0), sct_pkg::STAT_OK);
          idle_char(c, p);
        end
      end
      LEX_WORD: begin
        if (ends_word(c)) begin
          emit_tok(sct_pkg::KIND_WORD, tok_start, span(p, 1'b0), sct_pkg::STAT_OK);
          idle_char(c, p);
        end else begin
          word_char(c);
        end
      end
      LEX_ESC: begin
        // backslash right before the line end stays in the word
        if (c == sct_pkg::CH_NUL) begin
          emit_tok(sct_pkg::KIND_WORD, tok_start, span(p, 1'b0), sct_pkg::STAT_OK);
          idle_char(c, p);
        end else begin
          mode = LEX_WORD;
        end
      end
      LEX_DQ: begin
        if (c == sct_pkg::CH_NUL)
          emit_tok(sct_pkg::KIND_END, tok_start, span(p, 1'b0), sct_pkg::STAT_DQ);
        else if (c == sct_pkg::CH_DQUOTE) mode = LEX_WORD;
        else if (c == sct_pkg::CH_BSLASH) mode = LEX_DQESC;
      end
      LEX_DQESC: begin
        if (c == sct_pkg::CH_NUL)
          emit_tok(sct_pkg::KIND_END, tok_start, span(p, 1'b0), sct_pkg::STAT_DQ);
        else mode = LEX_DQ;
      end
      LEX_SQ: begin
        if (c == sct_pkg::CH_NUL)
          emit_tok(sct_pkg::KIND_END, tok_start, span(p, 1'b0), sct_pkg::STAT_SQ);
        else if (c == sct_pkg::CH_SQUOTE) mode = LEX_WORD;
      end
      default: idle_char(c, p);
    endcase

    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_tok[i]);

    // Line end restarts; otherwise the position saturates
    if (c == sct_pkg::CH_NUL) begin
      pos = '0;
      tok_start = '0;
      mode = LEX_IDLE;
    end else if (pos < MAX_LINE - 1) begin
      pos++;
    end
  endtask

  // Predict on accepted requests, compare accepted tokens
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = LEX_IDLE;
      pos = '0;
      tok_start = '0;
      expected_tokens.delete();
    end else begin
      if (in_valid_i && in_ready_i) lex_char(ch_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("arrived with none expected, kind", -1, token_kind_i);
        end else begin
          want = expected_tokens.pop_front();
          if (token_kind_i !== want.kind)
            report_mismatch("kind", want.kind, token_kind_i);
          if (token_start_i !== want.start)
            report_mismatch("start", want.start, token_start_i);
          if (token_length_i !== want.length)
            report_mismatch("length", want.length, token_length_i);
          if (status_i !== want.status)
            report_mismatch("status", want.status, status_i);
          if (last_i !== want.last)
            report_mismatch("last", want.last, last_i);
          checked++;
        end
      end
    end
    pending = expected_tokens.size();
  end

endmodule

>>> test/shell_command_tokenizer_tb.sv
`timescale 1ns / 1ps

module shell_command_tokenizer_tb;

  localparam int unsigned MaxLine = sct_pkg::MaxLineDefault;
  localparam int RandomChars = 1200;
  localparam int LongLineChars = 4200;
  localparam int HoldCycles = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  token_kind;
  logic [11:0] token_start;
  logic [12:0] token_length;
  logic [1:0]  status;
  logic        last;

  // Pressure controls shared with the receiver
  logic hold_req = 1'b0;
  logic quiet = 1'b0;

  int fail_count;
  int pending;
  int checked;
  int chars_sent = 0;
  int lines_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  shell_command_tokenizer #(
    .MAX_LINE(MaxLine)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .ch_i          (ch),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_o  (token_kind),
    .token_start_o (token_start),
    .token_length_o(token_length),
    .status_o      (status),
    .last_o        (last)
  );

  sct_token_checker #(
    .MAX_LINE(MaxLine)
  ) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .ch_i          (ch),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_i  (token_kind),
    .token_start_i (token_start),
    .token_length_i(token_length),
    .status_i      (status),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Receiver: random stalls, a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 23);
      end
    end
  end

  // Offer one character, with an occasional gap before it
  task automatic send_char(input logic [7:0] c);
    if (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stop offering until every predicted token has come out
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Any byte but zero, backslash and the excluded one
  function automatic logic [7:0] any_but(input logic [7:0] excl);
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == excl || c == sct_pkg::CH_BSLASH) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic send_quoted(input logic [7:0] q);
    send_char(q);
    repeat ($urandom_range(0, 4)) begin
      if (q == sct_pkg::CH_DQUOTE && $urandom_range(4) == 0) begin
        send_char(sct_pkg::CH_BSLASH);
        send_char(any_but(sct_pkg::CH_NUL));
      end else begin
        send_char(any_but(q));
      end
    end
  endtask

  task automatic send_word;
    string punct;
    int r;
    punct = "!$%&()*+,-./:<=>?@[]^_`{|}~";
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(99);
      if (r < 55) begin
        send_char(8'("a" + $urandom_range(25)));
      end else if (r < 65) begin
        send_char(sct_pkg::CH_ZERO + 8'($urandom_range(9)));
      end else if (r < 75) begin
        send_quoted(sct_pkg::CH_DQUOTE);
        send_char(sct_pkg::CH_DQUOTE);
      end else if (r < 85) begin
        send_quoted(sct_pkg::CH_SQUOTE);
        send_char(sct_pkg::CH_SQUOTE);
      end else if (r < 92) begin
        send_char(sct_pkg::CH_BSLASH);
        send_char(any_but(sct_pkg::CH_NUL));
      end else begin
        send_char(punct[$urandom_range(punct.len() - 1)]);
      end
    end
  endtask

  task automatic send_redirect;
    if ($urandom_range(1)) send_char(sct_pkg::CH_ZERO + 8'($urandom_range(9)));
    send_char(sct_pkg::CH_GT);
    if ($urandom_range(1)) send_char(sct_pkg::CH_GT);
    if ($urandom_range(4) < 2) send_char(sct_pkg::CH_AMP);
  endtask

  task automatic send_separator;
    case ($urandom_range(9))
      6: send_char(sct_pkg::CH_SEMI);
      7: send_char(sct_pkg::CH_NL);
      8: begin
        send_char(sct_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) send_char(any_but(sct_pkg::CH_NL));
        send_char(sct_pkg::CH_NL);
      end
      // tokens glued together
      9: ;
      default: repeat ($urandom_range(1, 2)) send_char(sct_pkg::CH_SPACE);
    endcase
  endtask

  // One random line: mostly well formed, some broken, some raw noise
  task automatic send_line;
    int r;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(2, 12)) send_char(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(3) == 0) send_redirect();
        else send_word();
        send_separator();
      end
      if (r < 22) begin
        case ($urandom_range(4))
          0: send_quoted(sct_pkg::CH_DQUOTE);
          1: send_quoted(sct_pkg::CH_SQUOTE);
          2: begin
            send_char(sct_pkg::CH_DQUOTE);
            send_char(sct_pkg::CH_BSLASH);
          end
          3: begin
            send_word();
            send_char(sct_pkg::CH_BSLASH);
          end
          default: begin
            send_char(sct_pkg::CH_HASH);
            send_char(any_but(sct_pkg::CH_NL));
          end
        endcase
      end
    end
    send_char(sct_pkg::CH_NUL);
    lines_sent++;
  endtask

  // Run time limit
  initial begin
    #(1_000_000);
    $display("timeout with %0d tokens still expected", pending);
    $display("** shell_command_tokenizer: FAILED **");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int base;
    logic held;
    held = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines: every token kind, comments, quotes left open, odd endings
    send_text("9q >&#z\n");
    send_char(sct_pkg::CH_NUL);
    send_text("1>>x;");
    send_char(8'hff);
    send_char(sct_pkg::CH_NUL);
    send_text("'a");
    send_char(sct_pkg::CH_NUL);
    send_text("\"\\");
    send_char(sct_pkg::CH_NUL);
    send_text("b\\");
    send_char(sct_pkg::CH_NUL);
    send_char(sct_pkg::CH_GT);
    send_char(sct_pkg::CH_NUL);
    lines_sent += 6;
    drain();

    // One line past the saturation point of the position counter
    for (int i = 0; i < LongLineChars; i++) send_char((i % 9 == 8) ? sct_pkg::CH_SPACE : "k");
    send_char(sct_pkg::CH_NUL);
    lines_sent++;
    drain();

    // Random lines with a receiver hold-off and a stretch without gaps
    base = chars_sent;
    while (chars_sent - base < RandomChars) begin
      if (!held && chars_sent - base > 300) begin
        in_valid <= 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        held = 1'b1;
      end
      quiet <= (chars_sent - base >= 600) && (chars_sent - base < 850);
      send_line();
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d characters in %0d lines (one of %0d characters), %0d tokens checked.",
             chars_sent, lines_sent, LongLineChars, checked);
    $display("Covered all token kinds, open quotes, comments, noise and backpressure.");
    if (fail_count == 0) begin
      $display("** shell_command_tokenizer: PASSED **");
    end else begin
      $display("** shell_command_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
design/sct_pkg.sv
design/sct_res_fifo.sv
design/shell_command_tokenizer.sv
test/sct_token_checker.sv
test/shell_command_tokenizer_tb.sv
